// ----- hw/rtl/ddf_pkg.sv -----
// shared constants, types and functions of the decimal digit display formatter
// no dependencies; imported by every module of the block
`default_nettype none

package ddf_pkg;

    // input value and conversion sizes
    localparam int VALUE_W     = 40;
    localparam int BCD_DIGITS  = 13;                  // digits of the widest 40-bit value
    localparam int BCD_W       = BCD_DIGITS * 4;
    localparam int BITS_PER_STEP = 4;
    localparam int DD_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W       = $clog2(DD_STEPS);

    // display side
    localparam int DIGIT_COUNT = 12;
    localparam int IDX_W       = $clog2(DIGIT_COUNT);
    localparam int BASE_W      = 3;
    localparam int POS_W       = 6;
    localparam int DIG_W       = 4;
    localparam int OUT_DATA_W  = 16;
    localparam int SEP_STRIDE  = 3;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DIGIT_COUNT - 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DD_STEPS - 1);

    // converter to queue request
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } ddf_push_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } ddf_qstat_t;

    // four double-dabble steps: add-3 correction then shift in one input bit
    function automatic logic [BCD_W-1:0] dd_nibble(input logic [BCD_W-1:0] bcd_in,
                                                   input logic [BITS_PER_STEP-1:0] nib);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int b = BITS_PER_STEP - 1; b >= 0; b--)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (acc[d*4 +: 4] >= 4'd5)
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
            end
            acc = {acc[BCD_W-2:0], nib[b]};
        end
        return acc;
    endfunction

    // thousands separator positions: every third index above zero
    function automatic logic is_sep(input logic [IDX_W-1:0] idx);
        logic hit;
        hit = 1'b0;
        for (int k = SEP_STRIDE; k < DIGIT_COUNT; k += SEP_STRIDE)
        begin
            if (idx == IDX_W'(k))
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ddf_front.sv -----
// front end: accepts a binary value and converts it to packed decimal digits
// four bits per cycle; depends on ddf_pkg
`default_nettype none

module ddf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ddf_pkg::VALUE_W-1:0]  s_tdata,   // [39:0] value
    input  wire ddf_pkg::ddf_qstat_t          q_stat,
    output ddf_pkg::ddf_push_t                push
);
    import ddf_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                accept;
    logic                pushed;

    // handshake: take a new value while the finished one leaves
    assign pushed     = done_reg && !q_stat.full;
    assign s_tready   = !busy_reg && (!done_reg || !q_stat.full);
    assign accept     = s_tvalid && s_tready;
    assign push.valid = done_reg;
    assign push.bcd   = bcd_reg;

    // conversion sequencer
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (pushed)
            done_next = 1'b0;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = s_tdata;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = dd_nibble(bcd_reg, bin_reg[VALUE_W-1 -: BITS_PER_STEP]);
            bin_next = {bin_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ddf_queue.sv -----
// two-entry queue of converted values between front and back
// depends on ddf_pkg
`default_nettype none

module ddf_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ddf_pkg::ddf_push_t         push,
    input  wire logic                       pop,
    output ddf_pkg::ddf_qstat_t             q_stat,
    output logic [ddf_pkg::BCD_W-1:0]       head
);
    import ddf_pkg::*;

    logic [BCD_W-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.bcd;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ddf_back.sv -----
// back end: walks the packed digits and issues one display write per cycle while the
// receiver is ready, through a registered output; depends on ddf_pkg
`default_nettype none

module ddf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ddf_pkg::BASE_W-1:0]    display_base,
    input  wire ddf_pkg::ddf_qstat_t           q_stat,
    input  wire logic [ddf_pkg::BCD_W-1:0]     head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ddf_pkg::OUT_DATA_W-1:0]     m_tdata,   // [5:0] position, [9:6] digit_value,
                                                          // [10] dot, [15:11] zero
    output logic                               m_tuser,   // [0] blank
    output logic                               m_tlast    // last
);
    import ddf_pkg::*;

    logic                  active_reg, active_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [BCD_W-1:0]      cur_reg, cur_next;
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DIG_W-1:0]      dig_reg, dig_next;
    logic                  dot_reg, dot_next;
    logic                  blank_reg, blank_next;
    logic                  last_reg, last_next;
    logic                  out_free;
    logic                  emit;
    logic                  is_blank;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = active_reg && out_free;
    assign pop      = !q_stat.empty && (!active_reg || (emit && idx_reg == LAST_IDX));
    // blank once no nonzero digit remains at or above this position, except at position zero
    assign is_blank = (cur_reg == '0) && (idx_reg != '0);

    // digit walker and output register
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pos_next       = pos_reg;
        dig_next       = dig_reg;
        dot_next       = dot_reg;
        blank_next     = blank_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pos_next   = {display_base, 3'b000} + {{(POS_W-IDX_W){1'b0}}, idx_reg};
            dig_next   = cur_reg[DIG_W-1:0];
            blank_next = is_blank;
            dot_next   = !is_blank && is_sep(idx_reg);
            last_next  = (idx_reg == LAST_IDX);
            cur_next   = {4'b0000, cur_reg[BCD_W-1:4]};
            idx_next   = idx_reg + 1'b1;
            if (idx_reg == LAST_IDX)
                active_next = 1'b0;
        end
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            cur_next    = head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        pos_reg   <= pos_next;
        dig_reg   <= dig_next;
        dot_reg   <= dot_next;
        blank_reg <= blank_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-POS_W-DIG_W-1){1'b0}}, dot_reg, dig_reg, pos_reg};
    assign m_tuser  = blank_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_digit_display_formatter_unit.sv -----
// decimal digit display formatter: value in, twelve display writes out
// path: an accepted value passes the converter, the queue, the digit walker and the output register
// output: twelve writes per value, one write per cycle from the output stage while m_tready is high;
//   the converter takes 4 bits per cycle and runs ahead via a 2-entry queue
// reset: clears all control state and sets display_base to 0; no clearing pass
// depends on ddf_pkg, ddf_front, ddf_queue, ddf_back
`default_nettype none

module decimal_digit_display_formatter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ddf_pkg::BASE_W-1:0]     cfg_wdata,  // display_base
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ddf_pkg::VALUE_W-1:0]    s_tdata,    // [39:0] value
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ddf_pkg::OUT_DATA_W-1:0]      m_tdata,    // [5:0] position, [9:6] digit_value,
                                                            // [10] dot, [15:11] zero
    output logic                                m_tuser,    // [0] blank
    output logic                                m_tlast     // last
);
    import ddf_pkg::*;

    logic [BASE_W-1:0] display_base_reg;
    ddf_push_t         push;
    ddf_qstat_t        q_stat;
    logic [BCD_W-1:0]  head;
    logic              pop;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            display_base_reg <= '0;
        else if (cfg_we)
            display_base_reg <= cfg_wdata;
    end

    ddf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push)
    );

    ddf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    ddf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .display_base (display_base_reg),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // queue can never be full and empty at once
    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // converter is busy right after taking a value
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("converter took two values back to back");

    // a blank position carries neither digit nor dot
    a_blank_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[10:6] == 5'd0))
        else $error("blank position with digit or dot");

    // a pop is only issued while the queue holds a value
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- tb/tb_decimal_digit_display_formatter_unit.sv -----
// self-checking testbench of decimal_digit_display_formatter_unit: values in, display writes out
// needs ddf_pkg and the rtl of the block; directed table first, then random values per base
`timescale 1ns / 100ps

module tb_decimal_digit_display_formatter_unit;

    import ddf_pkg::*;

    localparam int NIB_W       = 4 * DIGIT_COUNT;
    localparam int GAP_MAX     = 17;
    localparam int PHASE_ITEMS = 26;

    // one expected display write
    typedef struct {
        logic [POS_W-1:0] position;
        logic             blank;
        logic [DIG_W-1:0] digit;
        logic             dot;
        logic             last;
    } disp_write_t;

    // one directed stimulus row; typed rows carry their digits and blank mask
    typedef struct {
        int                     base;
        logic [VALUE_W-1:0]     value;
        bit                     typed;
        logic [NIB_W-1:0]       nibs;
        logic [DIGIT_COUNT-1:0] blanks;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [BASE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    disp_write_t        pending_writes[$];
    stim_row_t          stim_table[$];
    logic [BASE_W-1:0]  display_base_q;
    int                 src_rate;
    int                 sink_rate;
    int                 n_errors;
    int                 n_values;
    int                 n_checked;
    int                 n_directed;
    int                 n_settings;

    decimal_digit_display_formatter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mismatch report
    task automatic flag(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    // decimal digits of a value and the mask of blanked positions
    function automatic void split_decimal(input logic [VALUE_W-1:0] val,
                                          output logic [NIB_W-1:0] nibs,
                                          output logic [DIGIT_COUNT-1:0] blanks);
        longint unsigned v;
        longint unsigned t;
        longint unsigned lim;
        int shown;
        lim = 1;
        for (int k = 0; k < DIGIT_COUNT; k++)
            lim = lim * 10;
        v = val;
        if (v >= lim)
        begin
            v = v % lim;
            shown = DIGIT_COUNT;
        end
        else if (v == 0)
            shown = 1;
        else
        begin
            t = v;
            shown = 0;
            while (t != 0)
            begin
                t = t / 10;
                shown++;
            end
        end
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            nibs[i*4 +: 4] = (i < shown) ? 4'(v % 10) : 4'd0;
            blanks[i]      = (i >= shown);
            v = v / 10;
        end
    endfunction

    // expand digits and blank mask into the twelve writes at the current base
    task automatic queue_writes(input logic [NIB_W-1:0] nibs, input logic [DIGIT_COUNT-1:0] blanks);
        disp_write_t w;
        int addr;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            addr       = (int'(display_base_q) * 8 + i) % 64;
            w.position = addr[POS_W-1:0];
            w.blank    = blanks[i];
            w.digit    = nibs[i*4 +: 4];
            w.dot      = !blanks[i] && i > 0 && (i % 3) == 0;
            w.last     = (i == DIGIT_COUNT - 1);
            pending_writes.push_back(w);
        end
    endtask

    task automatic add_row(input int base, input logic [VALUE_W-1:0] value, input bit typed,
                           input logic [NIB_W-1:0] nibs, input logic [DIGIT_COUNT-1:0] blanks);
        stim_row_t r;
        r.base   = base;
        r.value  = value;
        r.typed  = typed;
        r.nibs   = nibs;
        r.blanks = blanks;
        stim_table.push_back(r);
    endtask

    // send one value request, with an optional gap before it
    task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input logic [NIB_W-1:0] nibs, input logic [DIGIT_COUNT-1:0] blanks);
        logic [NIB_W-1:0]       pn;
        logic [DIGIT_COUNT-1:0] pb;
        if (src_rate != 0 && $urandom_range(1, src_rate) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
        begin
            pn = nibs;
            pb = blanks;
        end
        else
            split_decimal(v, pn, pb);
        queue_writes(pn, pb);
        n_values++;
    endtask

    // stop sending and wait for every pending write
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_base(input logic [BASE_W-1:0] b);
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_we    <= 1'b0;
        display_base_q = b;
        n_settings++;
    endtask

    // random value: full width, small, zero, too wide, or built digit by digit
    function automatic logic [VALUE_W-1:0] pick_value;
        longint unsigned v;
        longint unsigned raw;
        int n;
        int zero_odds;
        raw = {$urandom_range(0, 255), $urandom};
        case ($urandom_range(0, 9))
            0: v = raw;
            1: v = $urandom_range(0, 99);
            2: v = 0;
            3: v = 64'd1_000_000_000_000 + raw % (64'd1099511627776 - 64'd1_000_000_000_000);
            default:
            begin
                n = $urandom_range(1, DIGIT_COUNT);
                zero_odds = $urandom_range(1, 4);
                v = $urandom_range(1, 9);
                for (int k = 1; k < n; k++)
                begin
                    if ($urandom_range(1, zero_odds) == 1)
                        v = v * 10;
                    else
                        v = v * 10 + $urandom_range(0, 9);
                end
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // receiver side stalls
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (sink_rate != 0 && $urandom_range(1, sink_rate) == 1)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each write with the oldest pending one
    always @(posedge clk)
    begin
        disp_write_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
                flag("write with none pending, tdata", m_tdata, 16'h0);
            else
            begin
                want = pending_writes.pop_front();
                if (m_tdata[POS_W-1:0] !== want.position)
                    flag("position", m_tdata[POS_W-1:0], want.position);
                if (m_tuser !== want.blank)
                    flag("blank", m_tuser, want.blank);
                if (m_tdata[POS_W +: DIG_W] !== want.digit)
                    flag("digit_value", m_tdata[POS_W +: DIG_W], want.digit);
                if (m_tdata[POS_W+DIG_W] !== want.dot)
                    flag("dot", m_tdata[POS_W+DIG_W], want.dot);
                if (m_tlast !== want.last)
                    flag("last", m_tlast, want.last);
                if (m_tdata[OUT_DATA_W-1:POS_W+DIG_W+1] !== '0)
                    flag("tdata padding", m_tdata[OUT_DATA_W-1:POS_W+DIG_W+1], 16'h0);
                n_checked++;
            end
        end
    end

    // run limit
    initial
    begin
        #(5_000_000);
        $display("timeout at %0t ns, %0d writes still pending", $time, pending_writes.size());
        $display("** decimal_digit_display_formatter_unit: FAILED **");
        $finish;
    end

    // main sequence
    initial
    begin
        int phase_bases[8];
        stim_row_t r;
        phase_bases = '{3, 0, 5, 7, 2, 6, 4, 1};
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        display_base_q = '0;
        src_rate       = 0;
        sink_rate      = 0;
        n_errors       = 0;
        n_values       = 0;
        n_checked      = 0;
        n_directed     = 0;
        n_settings     = 0;

        // directed table: base 0 rows rely on the reset value
        add_row(0, 40'd0,             1, 48'h0,            12'hFFE);
        add_row(0, 40'd1,             1, 48'h1,            12'hFFE);
        add_row(0, 40'd9,             1, 48'h9,            12'hFFE);
        add_row(0, 40'd10,            1, 48'h10,           12'hFFC);
        add_row(0, 40'd999,           1, 48'h999,          12'hFF8);
        add_row(0, 40'd1000,          1, 48'h1000,         12'hFF0);
        add_row(0, 40'd10000,         1, 48'h10000,        12'hFE0);
        add_row(0, 40'd100000001,     0, '0,               '0);
        add_row(0, 40'd123456789012,  1, 48'h123456789012, 12'h000);
        add_row(0, 40'd999999999999,  1, 48'h999999999999, 12'h000);
        add_row(0, 40'd100000000000,  1, 48'h100000000000, 12'h000);
        // too wide: low twelve digits, no blanks
        add_row(0, 40'd1000000000000, 1, 48'h0,            12'h000);
        add_row(0, 40'hFFFFFFFFFF,    1, 48'h099511627775, 12'h000);
        add_row(0, 40'h5555555555,    0, '0,               '0);
        add_row(0, 40'hAAAAAAAAAA,    0, '0,               '0);
        // top base: positions wrap past 63
        add_row(7, 40'd0,             1, 48'h0,            12'hFFE);
        add_row(7, 40'd999999999999,  1, 48'h999999999999, 12'h000);
        add_row(7, 40'd123,           0, '0,               '0);
        add_row(7, 40'hFFFFFFFFFF,    1, 48'h099511627775, 12'h000);
        add_row(6, 40'd4567,          0, '0,               '0);
        add_row(6, 40'd100010001,     0, '0,               '0);
        add_row(1, 40'd8,             0, '0,               '0);
        add_row(1, 40'd700000000005,  0, '0,               '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        src_rate  = 6;
        sink_rate = 5;
        while (stim_table.size() != 0)
        begin
            r = stim_table.pop_front();
            if (r.base[BASE_W-1:0] != display_base_q)
            begin
                drain();
                set_base(r.base[BASE_W-1:0]);
            end
            send_value(r.value, r.typed, r.nibs, r.blanks);
            n_directed++;
        end

        // random phases, one base each; the last one runs without idling
        for (int p = 0; p < 8; p++)
        begin
            drain();
            set_base(phase_bases[p][BASE_W-1:0]);
            if (p == 7)
            begin
                src_rate  = 0;
                sink_rate = 0;
            end
            else
            begin
                src_rate  = $urandom_range(2, 10);
                sink_rate = $urandom_range(2, 10);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_value(pick_value(), 0, '0, '0);
        end

        drain();
        repeat (30) @(posedge clk);

        $display("sent %0d values (%0d from the directed table) over %0d base writes",
                 n_values, n_directed, n_settings);
        $display("checked %0d display writes field by field, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("** decimal_digit_display_formatter_unit: PASSED **");
        else
            $display("** decimal_digit_display_formatter_unit: FAILED **");
        $finish;
    end

endmodule
